[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by the rrsqm_checker module
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every rising clock edge out of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/rrsqm_pkg.sv]
// ---------------------------------------------------------------------------
// rrsqm_pkg
// types, codes and sizes shared by the switch queue monitor
// ---------------------------------------------------------------------------
`default_nettype none

package rrsqm_pkg;

    // switch geometry
    localparam int PORTS           = 16;
    localparam int OUTPUT_DEPTH    = 16;
    localparam int DEF_INPUT_DEPTH = 16;

    // derived widths
    localparam int PW      = $clog2(PORTS);
    localparam int NW      = $clog2(PORTS + 1);
    localparam int OCW     = $clog2(OUTPUT_DEPTH + 1);
    localparam int TW      = $clog2(PORTS * OUTPUT_DEPTH + 1);
    localparam int PHASE_W = 12;

    // field widths of the command and result words
    localparam int FUNC_W   = 2;
    localparam int PORT_W   = 4;
    localparam int DEST_W   = 5;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 9;
    localparam int PEAK_W   = 5;

    // configuration registers
    localparam int PCOUNT_W   = 5;
    localparam int FACTOR_W   = 8;
    localparam int PERIOD_W   = FACTOR_W + NW;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_PORT_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_FACTOR = 2'd1;

    localparam logic [PCOUNT_W-1:0] RST_PORT_COUNT   = 5'd16;
    localparam logic [FACTOR_W-1:0] RST_DRAIN_FACTOR = 8'd3;

    // command codes
    localparam logic [FUNC_W-1:0] FUNC_ENQUEUE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PEAK    = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_PORT    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_DEST    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_IN_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OUT_BLOCKED = 3'd4;

    // command word
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [PORT_W-1:0] port;
        logic [DEST_W-1:0] destination;
    } t_item;

    // result word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                forwarded;
        logic [PORT_W-1:0]   forward_source;
        logic [PORT_W-1:0]   forward_target;
        logic                drained;
        logic [TOTAL_W-1:0]  output_total;
        logic [TOTAL_W-1:0]  peak_total;
        logic [PEAK_W-1:0]   port_peak;
    } t_result;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic execute;
    } t_ctrl_cmd;

    // controller states
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

endpackage

`default_nettype wire

[rtl/rrsqm_ctrl.sv]
// ---------------------------------------------------------------------------
// rrsqm_ctrl
// command sequencer: capture a word, run the update, strobe the result
// ---------------------------------------------------------------------------
`default_nettype none

module rrsqm_ctrl
    import rrsqm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    output logic      o_strobe,
    output t_ctrl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_strobe;
    logic   n_strobe;

    // state and strobe registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        busy        = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = start;
            end
            S_EXEC: begin
                busy          = 1'b1;
                o_cmd.execute = 1'b1;
            end
            default: ;
        endcase
        n_strobe = o_cmd.execute;
    end

    assign o_strobe = r_strobe;

endmodule

`default_nettype wire

[rtl/rrsqm_datapath.sv]
// ---------------------------------------------------------------------------
// rrsqm_datapath
// input queues, output counters, drain timer and peak snapshot
// ---------------------------------------------------------------------------
`default_nettype none

module rrsqm_datapath
    import rrsqm_pkg::*;
#(
    parameter int INPUT_DEPTH = DEF_INPUT_DEPTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_ctrl_cmd             i_cmd,
    input  wire t_item                 i_item,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_result                    o_result
);

    localparam int HW = $clog2(INPUT_DEPTH);
    localparam int FW = $clog2(INPUT_DEPTH + 1);
    localparam logic [HW-1:0]  LAST_SLOT = HW'(INPUT_DEPTH - 1);
    localparam logic [FW-1:0]  FULL_FILL = FW'(INPUT_DEPTH);
    localparam logic [OCW-1:0] OUT_FULL  = OCW'(OUTPUT_DEPTH);

    // configuration
    logic [PCOUNT_W-1:0] r_port_count;
    logic [FACTOR_W-1:0] r_factor;

    // queue state
    logic [HW-1:0]      r_in_head [PORTS];
    logic [HW-1:0]      r_in_tail [PORTS];
    logic [FW-1:0]      r_in_fill [PORTS];
    logic [OCW-1:0]     r_out_fill [PORTS];
    logic [OCW-1:0]     r_peak_fill [PORTS];
    logic [PW-1:0]      r_ptr;
    logic [PHASE_W-1:0] r_phase;
    logic [TW-1:0]      r_total;
    logic [TW-1:0]      r_peak_sum;

    // packet destination store, one ring per input port
    logic [PW-1:0] r_mem [PORTS][INPUT_DEPTH];
    logic [PW-1:0] r_word;

    // captured command
    t_item         r_item;
    logic [PW-1:0] r_p;
    t_result       r_result;

    // combinational
    logic [NW-1:0]       n_act;
    logic [FACTOR_W-1:0] eff_factor;
    logic [PERIOD_W-1:0] period_calc;
    logic [PW-1:0]       p_now;
    logic [PW-1:0]       sel_idx;
    logic [PW-1:0]       rd_idx;
    logic [HW-1:0]       head_q;
    logic [HW-1:0]       tail_q;
    logic [FW-1:0]       fill_q;
    logic                tick;
    logic                port_ok;
    logic                dest_ok;
    logic                has_pkt;
    logic                blocked;
    logic                fwd_tick;
    logic                drain;
    logic                drain_tick;
    logic                in_push;
    logic                snap;
    logic [PHASE_W:0]    phase_inc;
    logic [NW-1:0]       p_inc;
    logic [PW-1:0]       ptr_next;
    logic [OCW-1:0]      of_a [PORTS];
    logic [OCW-1:0]      of_b [PORTS];
    logic [PORTS-1:0]    nz;
    logic [NW-1:0]       drain_cnt;
    logic [TW-1:0]       total_a;
    logic [TW-1:0]       total_b;
    t_result             res;

    // active port count and drain period
    always_comb begin
        if (r_port_count == '0) begin
            n_act = NW'(1);
        end else if (NW'(r_port_count) > NW'(PORTS)) begin
            n_act = NW'(PORTS);
        end else begin
            n_act = NW'(r_port_count);
        end
        eff_factor  = (r_factor == '0) ? FACTOR_W'(1) : r_factor;
        period_calc = PERIOD_W'(eff_factor) * PERIOD_W'(n_act);
    end

    // queue pointer lookup, one port address per cycle
    assign p_now   = (NW'(r_ptr) < n_act) ? r_ptr : '0;
    assign tick    = (r_item.func == FUNC_TICK);
    assign sel_idx = tick ? r_p : PW'(r_item.port);
    assign rd_idx  = i_cmd.capture ? p_now : sel_idx;
    assign head_q  = r_in_head[rd_idx];
    assign tail_q  = r_in_tail[rd_idx];
    assign fill_q  = r_in_fill[rd_idx];

    // tick: forward decision and drain timer
    assign has_pkt    = (fill_q != '0);
    assign blocked    = has_pkt && (r_out_fill[r_word] >= OUT_FULL);
    assign fwd_tick   = tick && has_pkt && !blocked;
    assign phase_inc  = {1'b0, r_phase} + (PHASE_W + 1)'(1);
    assign drain      = (PERIOD_W'(phase_inc) >= period_calc);
    assign drain_tick = tick && drain;
    assign p_inc      = NW'(r_p) + NW'(1);
    assign ptr_next   = (p_inc >= n_act) ? '0 : p_inc[PW-1:0];

    // output counters after forward and drain
    always_comb begin
        for (int i = 0; i < PORTS; i++) begin
            of_a[i] = r_out_fill[i] + OCW'(fwd_tick && (r_word == PW'(i)));
            nz[i]   = (of_a[i] != '0);
            of_b[i] = (drain_tick && nz[i]) ? of_a[i] - OCW'(1) : of_a[i];
        end
        drain_cnt = NW'($countones(nz));
        total_a   = r_total + TW'(fwd_tick);
        total_b   = drain_tick ? total_a - TW'(drain_cnt) : total_a;
        snap      = tick && (total_b > r_peak_sum);
    end

    // command decode and result word
    always_comb begin
        port_ok = (NW'(r_item.port) < n_act);
        dest_ok = (r_item.destination != '0) && (NW'(r_item.destination) <= n_act);
        in_push = 1'b0;
        res     = '0;
        res.status = ST_OK;
        unique case (r_item.func)
            FUNC_ENQUEUE: begin
                if (!port_ok) begin
                    res.status = ST_BAD_PORT;
                end else if (!dest_ok) begin
                    res.status = ST_BAD_DEST;
                end else if (fill_q >= FULL_FILL) begin
                    res.status = ST_IN_FULL;
                end else begin
                    in_push = 1'b1;
                end
            end
            FUNC_TICK: begin
                res.forward_source = PORT_W'(r_p);
                if (has_pkt) res.forward_target = PORT_W'(r_word);
                if (blocked) res.status = ST_OUT_BLOCKED;
                res.forwarded = fwd_tick;
                res.drained   = drain;
            end
            FUNC_PEAK: begin
                if (!port_ok) begin
                    res.status = ST_BAD_PORT;
                end else begin
                    res.port_peak = PEAK_W'(r_peak_fill[r_item.port]);
                end
            end
            default: ;
        endcase
        res.output_total = TOTAL_W'(tick ? total_b : r_total);
        res.peak_total   = TOTAL_W'(snap ? total_b : r_peak_sum);
    end

    // destination store: write on enqueue, read the served head on capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && in_push) begin
            r_mem[r_item.port][tail_q] <= PW'(r_item.destination - DEST_W'(1));
        end
        if (i_cmd.capture) begin
            r_word <= r_mem[rd_idx][head_q];
        end
    end

    // command capture and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
            r_p    <= p_now;
        end
        if (i_cmd.execute) begin
            r_result <= res;
        end
    end

    // configuration and queue state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_count <= RST_PORT_COUNT;
            r_factor     <= RST_DRAIN_FACTOR;
            r_in_head    <= '{default: '0};
            r_in_tail    <= '{default: '0};
            r_in_fill    <= '{default: '0};
            r_out_fill   <= '{default: '0};
            r_peak_fill  <= '{default: '0};
            r_ptr        <= '0;
            r_phase      <= '0;
            r_total      <= '0;
            r_peak_sum   <= '0;
        end else begin
            // register writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PORT_COUNT:   r_port_count <= i_cfg_data[PCOUNT_W-1:0];
                    CFG_DRAIN_FACTOR: r_factor     <= i_cfg_data[FACTOR_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.execute) begin
                // enqueue at tail
                if (in_push) begin
                    r_in_tail[r_item.port] <= (tail_q == LAST_SLOT) ? '0 : tail_q + HW'(1);
                    r_in_fill[r_item.port] <= fill_q + FW'(1);
                end
                // pop the forwarded head
                if (fwd_tick) begin
                    r_in_head[r_p] <= (head_q == LAST_SLOT) ? '0 : head_q + HW'(1);
                    r_in_fill[r_p] <= fill_q - FW'(1);
                end
                // counters, pointer, timer and peak
                if (tick) begin
                    r_out_fill <= of_b;
                    r_total    <= total_b;
                    r_ptr      <= ptr_next;
                    r_phase    <= drain ? '0 : phase_inc[PHASE_W-1:0];
                    if (snap) begin
                        r_peak_sum  <= total_b;
                        r_peak_fill <= of_b;
                    end
                end
            end
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire

[rtl/round_robin_switch_queue_monitor.sv]
// ---------------------------------------------------------------------------
// round_robin_switch_queue_monitor
// input-queued switch with round-robin service and congestion peak monitor
// ---------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Every command
// has two steps: the first reads the served port's head entry from
// the packet store memory, the second updates the queue and output counters;
// busy is high during the second step and the result word appears with
// o_strobe for one cycle right after it, so a new command can be started in
// the same cycle the previous result is shown. The receiver cannot stall:
// the strobe marks a result once; the word is held until the next command.
// Configuration words may be written at any time while no command is in
// flight; o_cfg_ready is always high. No clearing pass is needed after reset.
`default_nettype none

module round_robin_switch_queue_monitor
    import rrsqm_pkg::*;
#(
    parameter int INPUT_DEPTH = DEF_INPUT_DEPTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_item                 i_item,
    output logic                       o_strobe,
    output t_result                    o_result,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_ctrl_cmd cmd;
    logic      cfg_we;

    // configuration channel never pushes back
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;

    // sequencer
    rrsqm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_cmd    (cmd)
    );

    // queues and counters
    rrsqm_datapath #(
        .INPUT_DEPTH (INPUT_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

[rtl/rrsqm_checker.sv]
// ---------------------------------------------------------------------------
// rrsqm_checker
// port-level checks on command timing and reported occupancy
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rrsqm_checker
    import rrsqm_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire logic    o_strobe,
    input wire t_result o_result
);

    // every accepted word gives one result, strobed once its execute state has passed
    `ASSERT_CLK(a_accept_to_strobe, i_clk, i_rst_n, (start && !busy) |-> ##2 o_strobe, "accepted word gave no result")

    // no result without an accepted word
    `ASSERT_CLK(a_strobe_has_word, i_clk, i_rst_n, o_strobe |-> $past(start && !busy, 2), "result without accepted word")

    // the stored peak never falls below the live total
    `ASSERT_NEVER(a_peak_below_total, i_clk, i_rst_n, o_strobe && (o_result.peak_total < o_result.output_total), "peak total below output total")

    // a forwarded packet is never reported with an error
    `ASSERT_NEVER(a_fwd_with_error, i_clk, i_rst_n, o_strobe && o_result.forwarded && (o_result.status != ST_OK), "forward reported with error status")

endmodule

bind round_robin_switch_queue_monitor rrsqm_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

`default_nettype wire

[verif/switch_monitor_checker.sv]
// ----------------------------------------------------------------------------
// switch_monitor_checker
// Watches the command, result and configuration channels of the switch queue
// monitor. Keeps its own copy of the input queues, output counters, drain
// phase and peak snapshot, works out the result word for every accepted
// command and compares each strobed result, field by field, with the oldest
// one still owed.
// ----------------------------------------------------------------------------
module switch_monitor_checker
    import rrsqm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  t_item                 i_item,
    input  logic                  i_strobe,
    input  t_result               i_result,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_DEPTH = DEF_INPUT_DEPTH;
    localparam int IPW      = $clog2(IN_DEPTH);

    // switch configuration as last written
    logic [PCOUNT_W-1:0] port_count_q;
    logic [FACTOR_W-1:0] drain_factor_q;

    // input queues hold the output index of each waiting packet
    logic [PW-1:0]  queued_target [PORTS][IN_DEPTH];
    logic [IPW-1:0] in_head [PORTS];
    logic [IPW-1:0] in_tail [PORTS];
    logic [IPW:0]   in_fill [PORTS];

    // output counters and peak snapshot
    logic [OCW-1:0]     out_fill [PORTS];
    logic [OCW-1:0]     peak_fill [PORTS];
    logic [PW-1:0]      serve_ptr;
    logic [PHASE_W-1:0] drain_phase_q;
    logic [TW-1:0]      occupancy;
    logic [TW-1:0]      peak_occupancy;

    t_result pending_results[$];
    int      fail_total = 0;
    int      owed_now   = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = owed_now;

    // state after reset
    function automatic void clear_switch();
        port_count_q   = RST_PORT_COUNT;
        drain_factor_q = RST_DRAIN_FACTOR;
        serve_ptr      = '0;
        drain_phase_q  = '0;
        occupancy      = '0;
        peak_occupancy = '0;
        for (int i = 0; i < PORTS; i++) begin
            in_head[i]   = '0;
            in_tail[i]   = '0;
            in_fill[i]   = '0;
            out_fill[i]  = '0;
            peak_fill[i] = '0;
        end
    endfunction

    // apply one command word and return the result word it owes
    function automatic t_result advance_switch(input t_item w);
        t_result              r;
        int                   n;
        int                   p;
        int                   period;
        logic [DEST_W-1:0]    dm1;
        logic [PW-1:0]        tgt;
        r = '0;
        if (port_count_q == 0) n = 1;
        else if (port_count_q > PORTS) n = PORTS;
        else n = port_count_q;
        case (w.func)
            FUNC_ENQUEUE: begin
                if (w.port >= n) begin
                    r.status = ST_BAD_PORT;
                end else if (w.destination == 0 || w.destination > n) begin
                    r.status = ST_BAD_DEST;
                end else if (in_fill[w.port] >= IN_DEPTH) begin
                    r.status = ST_IN_FULL;
                end else begin
                    dm1 = w.destination - 1'b1;
                    queued_target[w.port][in_tail[w.port]] = dm1[PW-1:0];
                    in_tail[w.port] = in_tail[w.port] + 1'b1;
                    in_fill[w.port] = in_fill[w.port] + 1'b1;
                end
            end
            FUNC_TICK: begin
                p      = (serve_ptr < n) ? serve_ptr : 0;
                period = ((drain_factor_q == 0) ? 1 : drain_factor_q) * n;
                r.forward_source = p[PW-1:0];
                // serve the head packet unless its output queue is full
                if (in_fill[p] != 0) begin
                    tgt = queued_target[p][in_head[p]];
                    r.forward_target = tgt;
                    if (out_fill[tgt] >= OUTPUT_DEPTH) begin
                        r.status = ST_OUT_BLOCKED;
                    end else begin
                        out_fill[tgt] = out_fill[tgt] + 1'b1;
                        occupancy     = occupancy + 1'b1;
                        in_head[p]    = in_head[p] + 1'b1;
                        in_fill[p]    = in_fill[p] - 1'b1;
                        r.forwarded   = 1'b1;
                    end
                end
                serve_ptr = (p + 1 >= n) ? '0 : PW'(p + 1);
                // periodic drain covers every output queue, active or not
                drain_phase_q = drain_phase_q + 1'b1;
                if (drain_phase_q >= period) begin
                    drain_phase_q = '0;
                    r.drained     = 1'b1;
                    for (int i = 0; i < PORTS; i++) begin
                        if (out_fill[i] != 0) begin
                            out_fill[i] = out_fill[i] - 1'b1;
                            occupancy   = occupancy - 1'b1;
                        end
                    end
                end
                if (occupancy > peak_occupancy) begin
                    peak_occupancy = occupancy;
                    for (int i = 0; i < PORTS; i++) peak_fill[i] = out_fill[i];
                end
            end
            FUNC_PEAK: begin
                if (w.port >= n) r.status = ST_BAD_PORT;
                else r.port_peak = peak_fill[w.port];
            end
            default: ;
        endcase
        r.output_total = occupancy;
        r.peak_total   = peak_occupancy;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v) begin
            fail_total++;
            $display("%0t: %s expected %0d, actual %0d", $time, name, want_v, got_v);
        end
    endtask

    // compare strobed words, track config writes, predict accepted commands
    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            clear_switch();
            pending_results.delete();
        end else begin
            if (i_strobe) begin
                if (pending_results.size() == 0) begin
                    fail_total++;
                    $display("%0t: result word expected none, actual %h", $time, i_result);
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, i_result.status);
                    check_field("forwarded", want.forwarded, i_result.forwarded);
                    check_field("forward_source", want.forward_source,
                                i_result.forward_source);
                    check_field("forward_target", want.forward_target,
                                i_result.forward_target);
                    check_field("drained", want.drained, i_result.drained);
                    check_field("output_total", want.output_total, i_result.output_total);
                    check_field("peak_total", want.peak_total, i_result.peak_total);
                    check_field("port_peak", want.port_peak, i_result.port_peak);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PORT_COUNT:   port_count_q   = i_cfg_data[PCOUNT_W-1:0];
                    CFG_DRAIN_FACTOR: drain_factor_q = i_cfg_data[FACTOR_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) pending_results.push_back(advance_switch(i_item));
        end
        owed_now = pending_results.size();
    end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives the switch queue monitor with a short directed list of commands and
// then with random phases under different port counts and drain factors:
// balanced traffic, floods onto one output that fill both queue levels, and
// shrunken port counts that leave packets on inactive ports. The checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rrsqm_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
    localparam int IDLE_PCT = 27;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    t_item                 item;
    logic                  strobe;
    t_result               result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    bit                    calm;

    always #4 clk = ~clk;

    round_robin_switch_queue_monitor DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (item),
        .o_strobe    (strobe),
        .o_result    (result),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    switch_monitor_checker monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (item),
        .i_strobe     (strobe),
        .i_result     (result),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // hand one command word over; called and left at a falling edge
    task automatic issue(input logic [FUNC_W-1:0] f, input logic [PORT_W-1:0] p,
                         input logic [DEST_W-1:0] d);
        t_item w;
        w.func        = f;
        w.port        = p;
        w.destination = d;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        item  <= w;
        while (busy) @(negedge clk);
        @(negedge clk);
    endtask

    // hold off commands until every owed result word has come back
    task automatic settle();
        start <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    // write both registers back to back
    task automatic program_switch(input logic [PCOUNT_W-1:0] pc,
                                  input logic [FACTOR_W-1:0] factor);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_PORT_COUNT;
        cfg_data  <= {3'($urandom_range(0, 7)), pc};
        while (!cfg_ready) @(negedge clk);
        @(negedge clk);
        cfg_index <= CFG_DRAIN_FACTOR;
        cfg_data  <= factor;
        while (!cfg_ready) @(negedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one random phase under a given setting; flood aims most packets at destination 1
    task automatic run_phase(input logic [PCOUNT_W-1:0] pc, input logic [FACTOR_W-1:0] factor,
                             input int n, input int count, input bit flood);
        logic [FUNC_W-1:0] f;
        logic [PORT_W-1:0] p;
        logic [DEST_W-1:0] d;
        int                roll;
        settle();
        program_switch(pc, factor);
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(0, 99);
            if (flood) f = (roll < 55) ? FUNC_ENQUEUE : FUNC_TICK;
            else if (roll < 40) f = FUNC_ENQUEUE;
            else if (roll < 82) f = FUNC_TICK;
            else if (roll < 95) f = FUNC_PEAK;
            else f = FUNC_SPARE;
            if ($urandom_range(0, 9) == 0) p = $urandom_range(0, 15);
            else p = $urandom_range(0, n - 1);
            if (flood && $urandom_range(0, 3) != 0) d = 5'd1;
            else if ($urandom_range(0, 9) == 0) d = $urandom_range(0, 31);
            else d = $urandom_range(1, n);
            issue(f, p, d);
            if (k % 80 == 79) settle();
        end
    endtask

    initial begin
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_PORT_COUNT;
        cfg_data  = '0;
        calm      = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset setting, all sixteen ports active
        issue(FUNC_PEAK, 4'd0, 5'd0);
        issue(FUNC_SPARE, 4'd15, 5'd31);
        issue(FUNC_TICK, 4'd0, 5'd0);
        issue(FUNC_ENQUEUE, 4'd0, 5'd1);
        issue(FUNC_ENQUEUE, 4'd15, 5'd16);
        issue(FUNC_ENQUEUE, 4'd7, 5'd0);
        issue(FUNC_ENQUEUE, 4'd7, 5'd31);
        issue(FUNC_ENQUEUE, 4'd1, 5'd16);
        issue(FUNC_ENQUEUE, 4'd0, 5'd16);
        repeat (4) issue(FUNC_TICK, 4'd0, 5'd0);
        issue(FUNC_PEAK, 4'd15, 5'd16);
        issue(FUNC_PEAK, 4'd0, 5'd1);

        // directed: four ports, ports and destinations past the active range
        settle();
        program_switch(5'd4, 8'd1);
        issue(FUNC_ENQUEUE, 4'd15, 5'd2);
        issue(FUNC_PEAK, 4'd4, 5'd1);
        issue(FUNC_ENQUEUE, 4'd3, 5'd5);
        issue(FUNC_ENQUEUE, 4'd3, 5'd4);
        issue(FUNC_TICK, 4'd0, 5'd0);

        // random phases
        run_phase(5'd4, 8'd1, 4, 100, 1'b0);
        run_phase(5'd2, 8'd255, 2, 130, 1'b1);
        run_phase(5'd0, 8'd0, 1, 40, 1'b0);
        calm = 1'b1;
        run_phase(5'd31, 8'd2, 16, 110, 1'b0);
        calm = 1'b0;
        run_phase(5'd16, 8'd255, 16, 100, 1'b0);
        run_phase(5'd3, 8'd1, 3, 90, 1'b0);
        run_phase(5'd8, 8'd4, 8, 60, 1'b1);

        settle();
        repeat (4) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("** round_robin_switch_queue_monitor: PASSED **");
        end else begin
            $display("** round_robin_switch_queue_monitor: FAILED **");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("** round_robin_switch_queue_monitor: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/rrsqm_pkg.sv
rtl/rrsqm_ctrl.sv
rtl/rrsqm_datapath.sv
rtl/round_robin_switch_queue_monitor.sv
rtl/rrsqm_checker.sv
verif/switch_monitor_checker.sv
verif/testbench.sv
